/* rtl/core/first_fit_block_allocator_assert.svh */
// ----------------------------------------------------------------------------
// first fit block allocator assertion macros
// concurrent assertion wrappers used by the allocator sequencer rtl
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// checked outside of reset
`define FFBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_UNITS  = 4096;
    localparam int UNIT_BYTES = 32;
    localparam int ADDR_W     = $clog2(MAX_UNITS);
    localparam int HEAP_W     = ADDR_W + 1;
    localparam int BYTES_W    = 17;
    localparam int BSUM_W     = BYTES_W + 1;
    localparam int PADDR_W    = 3;

    localparam logic [HEAP_W-1:0] HEAP_MIN = HEAP_W'(3);
    localparam logic [HEAP_W-1:0] HEAP_MAX = HEAP_W'(MAX_UNITS);

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic       REG_HEAP_UNITS = 1'b0;

    typedef struct packed {
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] nxt;
        logic [ADDR_W-1:0] prv;
        logic              has_next;
        logic              has_prev;
        logic              free;
        logic              live;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [HEAP_W-1:0] clamp_units(input logic [HEAP_W-1:0] v);
        logic [HEAP_W-1:0] u;
        u = v;
        if (u < HEAP_MIN) begin
            u = HEAP_MIN;
        end
        if (u > HEAP_MAX) begin
            u = HEAP_MAX;
        end
        return u;
    endfunction

    function automatic logic [HEAP_W-1:0] units_needed(input logic [BYTES_W-1:0] b);
        logic [BSUM_W-1:0] s;
        s = BSUM_W'(b) + BSUM_W'(UNIT_BYTES - 1);
        s = BSUM_W'(s / UNIT_BYTES);
        return HEAP_W'(s) + HEAP_W'(1);
    endfunction

endpackage

/* rtl/core/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first fit allocator over a unit arena, apb size register, command interface
// ----------------------------------------------------------------------------
// Each transaction yields one result strobed on o_done for a single cycle; the
// receiver cannot stall it. A free reads the header and its successor before it
// writes; an allocate reads one header per block walked, and a split adds writes
// of the successor's back link and the new header, so its latency grows with the
// number of blocks ahead of the fit. After reset and after every heap_units write
// the arena memory is swept and initialised with busy high; start is taken only
// when busy is low.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [BYTES_W-1:0] i_request_bytes,
    input  logic [ADDR_W-1:0]  i_block_handle,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [ADDR_W-1:0]  o_granted_handle,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [HEAP_W-1:0] r_heap_units;
    logic              w_wr;
    logic              w_init;
    t_mem_req          w_mem;
    logic [ENTRY_W-1:0] w_rdata;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_init = w_wr && (paddr[PADDR_W-1] == REG_HEAP_UNITS);
    assign prdata = (paddr[PADDR_W-1] == REG_HEAP_UNITS) ? 32'(r_heap_units) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_units <= HEAP_MAX;
        end else if (w_init) begin
            r_heap_units <= clamp_units(pwdata[HEAP_W-1:0]);
        end
    end

    ffba_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_init           (w_init),
        .i_heap_units     (r_heap_units),
        .i_start          (start),
        .i_op             (i_op),
        .i_request_bytes  (i_request_bytes),
        .i_block_handle   (i_block_handle),
        .o_busy           (busy),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_granted_handle (o_granted_handle),
        .o_mem            (w_mem),
        .i_rdata          (t_entry'(w_rdata))
    );

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_UNITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

endmodule

/* rtl/core/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl
// sequencer: arena clear and init, first fit walk with split, checked free
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_assert.svh"

module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  logic [HEAP_W-1:0] i_heap_units,
    input  logic              i_start,
    input  logic              i_op,
    input  logic [BYTES_W-1:0] i_request_bytes,
    input  logic [ADDR_W-1:0] i_block_handle,
    output logic              o_busy,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_granted_handle,
    output t_mem_req          o_mem,
    input  t_entry            i_rdata
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_INIT0 = 9'b000000100,
        S_INIT1 = 9'b000001000,
        S_AWALK = 9'b000010000,
        S_ANXT  = 9'b000100000,
        S_ANB   = 9'b001000000,
        S_FRD1  = 9'b010000000,
        S_FRD2  = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_steps, n_steps;
    logic [ADDR_W-1:0] r_cur, n_cur;
    logic [ADDR_W-1:0] r_nb, n_nb;
    logic [HEAP_W-1:0] r_need, n_need;
    t_entry            r_ent, n_ent;
    logic              r_done, n_done;
    logic [1:0]        r_status, n_status;
    logic [ADDR_W-1:0] r_granted, n_granted;

    logic [ADDR_W-1:0] w_last;
    logic [ADDR_W-1:0] w_newlen;
    logic [HEAP_W-1:0] w_nb;
    logic [ADDR_W-1:0] w_hdr;
    t_entry            w_e;

    assign w_last   = ADDR_W'(i_heap_units - HEAP_W'(1));
    assign w_newlen = ADDR_W'(HEAP_W'(i_rdata.len) - r_need);
    assign w_nb     = HEAP_W'(r_cur) + HEAP_W'(w_newlen);
    assign w_hdr    = i_block_handle - ADDR_W'(1);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_steps   = r_steps;
        n_cur     = r_cur;
        n_nb      = r_nb;
        n_need    = r_need;
        n_ent     = r_ent;
        n_done    = 1'b0;
        n_status  = r_status;
        n_granted = r_granted;
        o_mem     = '0;
        w_e       = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_cnt;
                n_cnt       = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(MAX_UNITS - 1)) begin
                    n_state = S_INIT0;
                end
            end
            S_INIT0: begin
                w_e.len      = w_last;
                w_e.nxt      = w_last;
                w_e.has_next = 1'b1;
                w_e.free     = 1'b1;
                w_e.live     = 1'b1;
                o_mem.we     = 1'b1;
                o_mem.wdata  = w_e;
                n_state      = S_INIT1;
            end
            S_INIT1: begin
                w_e.has_prev = 1'b1;
                w_e.live     = 1'b1;
                o_mem.we     = 1'b1;
                o_mem.waddr  = w_last;
                o_mem.wdata  = w_e;
                n_state      = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_granted = '0;
                    if (i_op == OP_ALLOC) begin
                        n_need      = units_needed(i_request_bytes);
                        n_cur       = '0;
                        n_steps     = '0;
                        o_mem.raddr = '0;
                        n_state     = S_AWALK;
                    end else if (i_block_handle == '0) begin
                        n_status = ST_NULL;
                        n_done   = 1'b1;
                    end else if (HEAP_W'(w_hdr) >= i_heap_units) begin
                        n_status = ST_INVALID;
                        n_done   = 1'b1;
                    end else begin
                        n_cur       = w_hdr;
                        o_mem.raddr = w_hdr;
                        n_state     = S_FRD1;
                    end
                end
            end
            S_AWALK: begin
                if (i_rdata.free && HEAP_W'(i_rdata.len) >= r_need) begin
                    w_e         = i_rdata;
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_cur;
                    if (HEAP_W'(i_rdata.len) > r_need) begin
                        w_e.len = w_newlen;
                        if (w_nb >= i_heap_units) begin
                            // split point off the arena: length already cut
                            n_status = ST_NOMEM;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            w_e.nxt      = w_nb[ADDR_W-1:0];
                            w_e.has_next = 1'b1;
                            n_ent        = i_rdata;
                            n_nb         = w_nb[ADDR_W-1:0];
                            if (i_rdata.has_next && HEAP_W'(i_rdata.nxt) < i_heap_units) begin
                                o_mem.raddr = i_rdata.nxt;
                                n_state     = S_ANXT;
                            end else begin
                                n_state = S_ANB;
                            end
                        end
                    end else begin
                        w_e.free  = 1'b0;
                        n_status  = ST_OK;
                        n_granted = r_cur + ADDR_W'(1);
                        n_done    = 1'b1;
                        n_state   = S_IDLE;
                    end
                    o_mem.wdata = w_e;
                end else if (!i_rdata.has_next || r_steps == ADDR_W'(MAX_UNITS - 1)
                             || HEAP_W'(i_rdata.nxt) >= i_heap_units) begin
                    n_status = ST_NOMEM;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_cur       = i_rdata.nxt;
                    n_steps     = r_steps + ADDR_W'(1);
                    o_mem.raddr = i_rdata.nxt;
                end
            end
            S_ANXT: begin
                w_e          = i_rdata;
                w_e.prv      = r_nb;
                w_e.has_prev = 1'b1;
                o_mem.we     = 1'b1;
                o_mem.waddr  = r_ent.nxt;
                o_mem.wdata  = w_e;
                n_state      = S_ANB;
            end
            S_ANB: begin
                w_e.len      = ADDR_W'(r_need);
                w_e.nxt      = r_ent.nxt;
                w_e.has_next = r_ent.has_next;
                w_e.prv      = r_cur;
                w_e.has_prev = 1'b1;
                w_e.live     = 1'b1;
                o_mem.we     = 1'b1;
                o_mem.waddr  = r_nb;
                o_mem.wdata  = w_e;
                n_status     = ST_OK;
                n_granted    = r_nb + ADDR_W'(1);
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            S_FRD1: begin
                if (!i_rdata.live || !i_rdata.has_next
                    || HEAP_W'(i_rdata.nxt) >= i_heap_units) begin
                    n_status = ST_INVALID;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_ent       = i_rdata;
                    o_mem.raddr = i_rdata.nxt;
                    n_state     = S_FRD2;
                end
            end
            S_FRD2: begin
                if (!i_rdata.has_prev || i_rdata.prv != r_cur) begin
                    n_status = ST_INVALID;
                end else begin
                    w_e         = r_ent;
                    w_e.free    = 1'b1;
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_cur;
                    o_mem.wdata = w_e;
                    n_status    = ST_OK;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase

        // a new arena size restarts the clearing pass
        if (i_init) begin
            n_state = S_CLEAR;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps   <= n_steps;
        r_cur     <= n_cur;
        r_nb      <= n_nb;
        r_need    <= n_need;
        r_ent     <= n_ent;
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_granted_handle = r_granted;

    `FFBA_ASSERT_ALWAYS(a_done_idle, i_clk, r_done |-> (r_state == S_IDLE),
        "result while sequencer busy")
    `FFBA_ASSERT(a_idle_no_write, i_clk, i_rst_n, (r_state == S_IDLE) |-> !o_mem.we,
        "memory write while idle")
    `FFBA_ASSERT(a_fail_no_handle, i_clk, i_rst_n,
        (r_done && r_status != ST_OK) |-> (r_granted == '0), "handle granted on failure")
    `FFBA_ASSERT(a_walk_start, i_clk, i_rst_n,
        (i_start && !o_busy && i_op == OP_ALLOC && !i_init) |=> (r_cur == '0 && r_steps == '0),
        "walk not started at unit zero")

endmodule

/* verif/first_fit_block_allocator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_test
// self-checking bench: directed table then random allocate/free traffic over
// several arena sizes, results compared against table values or a first fit predictor
// ----------------------------------------------------------------------------
module first_fit_block_allocator_test;
    import ffba_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_op;
    logic [BYTES_W-1:0] i_request_bytes;
    logic [ADDR_W-1:0]  i_block_handle;
    logic               o_done;
    logic [1:0]         o_status;
    logic [ADDR_W-1:0]  o_granted_handle;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    first_fit_block_allocator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_request_bytes  (i_request_bytes),
        .i_block_handle   (i_block_handle),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_granted_handle (o_granted_handle),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_CFG  = 1'b1;

    typedef struct {
        logic               kind;
        logic               op;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  handle;
        bit                 typed;
        logic [1:0]         st;
        logic [ADDR_W-1:0]  gh;
    } t_row;

    typedef struct {
        logic [1:0]        st;
        logic [ADDR_W-1:0] gh;
    } t_outcome;

    // predicted arena state
    int  arena_units;
    int  unit_len  [MAX_UNITS];
    int  unit_next [MAX_UNITS];
    int  unit_prev [MAX_UNITS];
    bit  unit_hn   [MAX_UNITS];
    bit  unit_hp   [MAX_UNITS];
    bit  unit_free [MAX_UNITS];
    bit  unit_live [MAX_UNITS];

    t_outcome  pending_q[$];
    t_row      table_q[$];
    int        live_handles[$];
    int        freed_handles[$];
    int        mismatches;
    int        idle_pct;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic void arena_init(input int value);
        int last;
        arena_units = value & 32'h1FFF;
        if (arena_units < 3) arena_units = 3;
        if (arena_units > MAX_UNITS) arena_units = MAX_UNITS;
        last = arena_units - 1;
        for (int k = 0; k < MAX_UNITS; k++) begin
            unit_len[k] = 0; unit_next[k] = 0; unit_prev[k] = 0;
            unit_hn[k] = 0; unit_hp[k] = 0; unit_free[k] = 0; unit_live[k] = 0;
        end
        unit_len[0] = last; unit_next[0] = last; unit_hn[0] = 1;
        unit_free[0] = 1; unit_live[0] = 1;
        unit_prev[last] = 0; unit_hp[last] = 1; unit_live[last] = 1;
        live_handles.delete();
        freed_handles.delete();
    endfunction

    function automatic t_outcome first_fit_alloc(input int bytes);
        t_outcome res;
        int need, cur, nb;
        need = (bytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
        cur = 0;
        res.st = ST_NOMEM;
        res.gh = '0;
        for (int steps = 0; steps < MAX_UNITS; steps++) begin
            if (cur >= arena_units) break;
            if (unit_free[cur] && unit_len[cur] >= need) begin
                if (unit_len[cur] > need) begin
                    unit_len[cur] -= need;
                    nb = cur + unit_len[cur];
                    if (nb >= arena_units) return res;
                    unit_len[nb] = need;
                    unit_next[nb] = unit_next[cur];
                    unit_hn[nb] = unit_hn[cur];
                    unit_prev[nb] = cur;
                    unit_hp[nb] = 1;
                    unit_live[nb] = 1;
                    unit_next[cur] = nb;
                    unit_hn[cur] = 1;
                    if (unit_hn[nb] && unit_next[nb] < arena_units) begin
                        unit_prev[unit_next[nb]] = nb;
                        unit_hp[unit_next[nb]] = 1;
                    end
                    cur = nb;
                end
                unit_free[cur] = 0;
                res.st = ST_OK;
                res.gh = ADDR_W'(cur + 1);
                return res;
            end
            if (!unit_hn[cur]) break;
            cur = unit_next[cur];
        end
        return res;
    endfunction

    function automatic logic [1:0] release_block(input int handle);
        int hdr, nx;
        if (handle == 0) return ST_NULL;
        hdr = handle - 1;
        if (hdr >= arena_units || !unit_live[hdr] || !unit_hn[hdr]) return ST_INVALID;
        nx = unit_next[hdr];
        if (nx >= arena_units || !unit_hp[nx] || unit_prev[nx] != hdr) return ST_INVALID;
        unit_free[hdr] = 1;
        return ST_OK;
    endfunction

    function automatic void add_row(input logic kind, input logic op, input int bytes,
                                    input int handle, input bit typed,
                                    input logic [1:0] st, input int gh);
        t_row r;
        r.kind = kind; r.op = op; r.bytes = BYTES_W'(bytes); r.handle = ADDR_W'(handle);
        r.typed = typed; r.st = st; r.gh = ADDR_W'(gh);
        table_q.push_back(r);
    endfunction

    // drive one transaction and record its expected outcome once accepted
    task automatic issue(input logic op, input logic [BYTES_W-1:0] bytes,
                         input logic [ADDR_W-1:0] handle, input bit typed,
                         input logic [1:0] st, input logic [ADDR_W-1:0] gh);
        t_outcome exp_res;
        t_outcome pred;
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start           <= 1'b1;
        i_op            <= op;
        i_request_bytes <= bytes;
        i_block_handle  <= handle;
        do @(posedge i_clk); while (busy);
        if (op == OP_ALLOC) begin
            pred = first_fit_alloc(int'(bytes));
            if (pred.st == ST_OK) live_handles.push_back(int'(pred.gh));
        end else begin
            pred.st = release_block(int'(handle));
            pred.gh = '0;
        end
        exp_res = pred;
        if (typed) begin
            exp_res.st = st;
            exp_res.gh = gh;
        end
        pending_q.push_back(exp_res);
    endtask

    task automatic write_heap_units(input int value);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_HEAP_UNITS) << 2;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        arena_init(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_item();
        int r, k, bytes, handle;
        r = $urandom_range(0, 99);
        bytes = $urandom & 32'h1FFFF;
        handle = $urandom & 32'hFFF;
        if (r < 50) begin
            k = $urandom_range(0, 99);
            if (k < 70) bytes = $urandom_range(0, UNIT_BYTES * 4);
            else if (k < 90) bytes = $urandom_range(0, UNIT_BYTES * arena_units / 8);
            issue(OP_ALLOC, BYTES_W'(bytes), ADDR_W'(handle), 0, ST_OK, '0);
        end else begin
            k = $urandom_range(0, 99);
            if (k < 70 && live_handles.size() != 0) begin
                r = $urandom_range(0, live_handles.size() - 1);
                handle = live_handles[r];
                live_handles.delete(r);
                freed_handles.push_back(handle);
            end else if (k < 80) begin
                handle = 0;
            end else if (k < 90 && freed_handles.size() != 0) begin
                // double free of a released block
                handle = freed_handles[$urandom_range(0, freed_handles.size() - 1)];
            end
            issue(OP_FREE, BYTES_W'(bytes), ADDR_W'(handle), 0, ST_OK, '0);
        end
    endtask

    // result checker: the receiver cannot stall, every strobe is a transaction
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d handle %0d",
                             o_status, o_granted_handle);
            end else begin
                e = pending_q.pop_front();
                if (o_status !== e.st || o_granted_handle !== e.gh) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d handle %0d, got %0d %0d",
                                 e.st, e.gh, o_status, o_granted_handle);
                end
            end
        end
    end

    initial begin
        #300_000_000;
        $display("first_fit_block_allocator_test NOT OK");
        $finish;
    end

    initial begin
        int heap_list[8];
        int waited;
        mismatches = 0;
        idle_pct = 0;
        start = 1'b0;
        i_op = OP_ALLOC;
        i_request_bytes = '0;
        i_block_handle = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        arena_init(MAX_UNITS);
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: full arena after reset
        add_row(ROW_ITEM, OP_ALLOC, 0, 0, 1, ST_OK, 4095);
        add_row(ROW_ITEM, OP_ALLOC, 131071, 0, 1, ST_NOMEM, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 0, 1, ST_NULL, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 4095, 1, ST_OK, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 4095, 1, ST_OK, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 5, 1, ST_INVALID, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 1, 1, ST_OK, 0);
        add_row(ROW_ITEM, OP_ALLOC, 32, 4095, 0, ST_OK, 0);
        add_row(ROW_ITEM, OP_ALLOC, 1, 12'hFFF, 0, ST_OK, 0);
        add_row(ROW_ITEM, OP_FREE, 17'h1FFFF, 4093, 0, ST_OK, 0);
        // smallest arena, register below range
        add_row(ROW_CFG, OP_ALLOC, 0, 0, 0, ST_OK, 0);
        add_row(ROW_ITEM, OP_ALLOC, 0, 0, 1, ST_OK, 2);
        add_row(ROW_ITEM, OP_ALLOC, 0, 0, 1, ST_OK, 1);
        add_row(ROW_ITEM, OP_ALLOC, 0, 0, 1, ST_NOMEM, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 3, 1, ST_INVALID, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 4, 1, ST_INVALID, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 2, 1, ST_OK, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 1, 1, ST_OK, 0);
        add_row(ROW_ITEM, OP_ALLOC, 32, 0, 1, ST_NOMEM, 0);
        // register above range, exact fit of the whole arena
        add_row(ROW_CFG, OP_ALLOC, 8191, 0, 0, ST_OK, 0);
        add_row(ROW_ITEM, OP_ALLOC, 131008, 0, 1, ST_OK, 1);
        add_row(ROW_ITEM, OP_ALLOC, 0, 0, 1, ST_NOMEM, 0);
        add_row(ROW_ITEM, OP_FREE, 0, 1, 1, ST_OK, 0);
        add_row(ROW_ITEM, OP_ALLOC, 127968, 0, 0, ST_OK, 0);

        foreach (table_q[i]) begin
            if (table_q[i].kind == ROW_CFG)
                write_heap_units(int'(table_q[i].bytes));
            else
                issue(table_q[i].op, table_q[i].bytes, table_q[i].handle,
                      table_q[i].typed, table_q[i].st, table_q[i].gh);
        end

        heap_list = '{4096, 64, 3, 200, 4096, 0, 1000, 4096};
        heap_list[5] = $urandom_range(3, 4096);
        for (int p = 0; p < 8; p++) begin
            write_heap_units(heap_list[p]);
            case (p % 4)
                0: idle_pct = 0;
                1: idle_pct = 45;
                2: idle_pct = 0;
                default: idle_pct = 26;
            endcase
            for (int n = 0; n < 225; n++) random_item();
        end

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (pending_q.size() != 0 && waited < 100_000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("first_fit_block_allocator_test OK");
        end else begin
            $display("first_fit_block_allocator_test NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_ram.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator.sv
verif/first_fit_block_allocator_test.sv
